// ----- rtl/cosine_distance_accumulator_defines.svh -----
// Assertion macros for the cosine distance accumulator
`ifndef COSINE_DISTANCE_ACCUMULATOR_DEFINES_SVH
`define COSINE_DISTANCE_ACCUMULATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define CDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define CDA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cda_pkg.sv -----
// Shared types and constants of the cosine distance accumulator
`timescale 1ns / 1ps
package cda_pkg;

	localparam int ELEM_BITS   = 16;
	localparam int MAX_LEN_DEF = 4096;
	localparam int DIST_W      = 16;
	localparam int C2_W        = 31;
	localparam int L2_SHIFT    = 30;
	localparam int Q14_TWO     = 32768;
	localparam int ROUND_BASE  = 32769;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_START,
		ST_MUL_P,
		ST_MUL_M,
		ST_SEARCH,
		ST_LOAD_R,
		ST_MUL_R,
		ST_FINISH
	} cda_state_t;

	typedef enum logic [1:0] {
		MSEL_P,
		MSEL_M,
		MSEL_R
	} cda_msel_t;

	typedef struct packed {
		logic      acc_en;
		logic      mul_init;
		cda_msel_t mul_sel;
		logic      mul_step;
		logic      save_p;
		logic      save_l2;
		logic      search_init;
		logic      square;
		logic      decide;
		logic      finish;
	} cda_cmd_t;

	typedef struct packed {
		logic zero_norm;
		logic mul_done;
		logic search_done;
		logic out_busy;
	} cda_status_t;

endpackage

// ----- rtl/cda_if.sv -----
// Channel interfaces for element pairs and distance results
`timescale 1ns / 1ps
interface cda_sample_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] a_elem;
	logic signed [15:0] b_elem;
	logic        last;

	modport source (output valid, a_elem, b_elem, last, input ready);
	modport sink (input valid, a_elem, b_elem, last, output ready);
endinterface

interface cda_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] distance;
	logic        zero_norm;
	logic        too_long;

	modport source (output valid, distance, zero_norm, too_long, input ready);
	modport sink (input valid, distance, zero_norm, too_long, output ready);
endinterface

// ----- rtl/cda_ctrl.sv -----
// Controller state machine of the cosine distance accumulator
`timescale 1ns / 1ps
module cda_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_ready,
	input  cda_pkg::cda_status_t status,
	output cda_pkg::cda_cmd_t    cmd
);

	cda_pkg::cda_state_t state_q;
	cda_pkg::cda_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cda_pkg::ST_ACC: begin
				if (in_valid && in_last) state_d = cda_pkg::ST_START;
			end
			cda_pkg::ST_START: begin
				state_d = status.zero_norm ? cda_pkg::ST_FINISH : cda_pkg::ST_MUL_P;
			end
			cda_pkg::ST_MUL_P: begin
				if (status.mul_done) state_d = cda_pkg::ST_MUL_M;
			end
			cda_pkg::ST_MUL_M: begin
				if (status.mul_done) state_d = cda_pkg::ST_SEARCH;
			end
			cda_pkg::ST_SEARCH: begin
				state_d = status.search_done ? cda_pkg::ST_FINISH : cda_pkg::ST_LOAD_R;
			end
			cda_pkg::ST_LOAD_R: begin
				state_d = cda_pkg::ST_MUL_R;
			end
			cda_pkg::ST_MUL_R: begin
				if (status.mul_done) state_d = cda_pkg::ST_SEARCH;
			end
			cda_pkg::ST_FINISH: begin
				if (!status.out_busy) state_d = cda_pkg::ST_ACC;
			end
			default: begin
				state_d = cda_pkg::ST_ACC;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = cda_pkg::MSEL_P;
		in_ready = 1'b0;
		case (state_q)
			cda_pkg::ST_ACC: begin
				in_ready   = 1'b1;
				cmd.acc_en = in_valid;
			end
			cda_pkg::ST_START: begin
				cmd.mul_init    = !status.zero_norm;
				cmd.search_init = !status.zero_norm;
			end
			cda_pkg::ST_MUL_P: begin
				cmd.mul_step = !status.mul_done;
				cmd.save_p   = status.mul_done;
				cmd.mul_init = status.mul_done;
				cmd.mul_sel  = cda_pkg::MSEL_M;
			end
			cda_pkg::ST_MUL_M: begin
				cmd.mul_step = !status.mul_done;
				cmd.save_l2  = status.mul_done;
			end
			cda_pkg::ST_SEARCH: begin
				cmd.square = !status.search_done;
			end
			cda_pkg::ST_LOAD_R: begin
				cmd.mul_init = 1'b1;
				cmd.mul_sel  = cda_pkg::MSEL_R;
			end
			cda_pkg::ST_MUL_R: begin
				cmd.mul_step = !status.mul_done;
				cmd.decide   = status.mul_done;
			end
			cda_pkg::ST_FINISH: begin
				cmd.finish = !status.out_busy;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/cda_datapath.sv -----
// Accumulators, shift-add multiplier and rounding search of the distance unit
`timescale 1ns / 1ps
module cda_datapath #(
	parameter int MAX_LEN = cda_pkg::MAX_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [cda_pkg::ELEM_BITS-1:0] a_elem,
	input  logic signed [cda_pkg::ELEM_BITS-1:0] b_elem,
	input  cda_pkg::cda_cmd_t                 cmd,
	output cda_pkg::cda_status_t              status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cda_pkg::DIST_W-1:0]        distance,
	output logic                              zero_norm,
	output logic                              too_long
);

	localparam int EB    = cda_pkg::ELEM_BITS;
	localparam int SQ_W  = 2 * EB - 1 + $clog2(MAX_LEN);
	localparam int CR_W  = SQ_W + 1;
	localparam int P_W   = 2 * SQ_W;
	localparam int WIDE  = P_W + cda_pkg::L2_SHIFT;
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int DW    = cda_pkg::DIST_W;

	logic [SQ_W-1:0]        sum_sq_a_q;
	logic [SQ_W-1:0]        sum_sq_b_q;
	logic signed [CR_W-1:0] sum_cross_q;
	logic [CNT_W-1:0]       pair_count_q;
	logic                   overflow_q;

	logic [WIDE-1:0] mx_q;
	logic [SQ_W-1:0] my_q;
	logic [WIDE-1:0] macc_q;
	logic [P_W-1:0]  p_q;
	logic [WIDE-1:0] l2_q;

	logic [DW-1:0]        lo_q;
	logic [DW-1:0]        hi_q;
	logic [DW-1:0]        mid_q;
	logic                 c_neg_q;
	logic [cda_pkg::C2_W-1:0] c2_q;

	logic [DW-1:0] dist_q;
	logic          zn_q;
	logic          tl_q;
	logic          out_valid_q;

	logic signed [2*EB-1:0] prod_aa;
	logic signed [2*EB-1:0] prod_bb;
	logic signed [2*EB-1:0] prod_ab;
	logic signed [CR_W-1:0] cross_abs;
	logic [SQ_W-1:0]        mag;
	logic [DW:0]            mid_sum;
	logic [DW-1:0]          mid;
	logic signed [DW+1:0]   c_full;
	logic signed [DW+1:0]   c_abs_full;
	logic [2*DW-1:0]        c_sq;
	logic                   ab_neg;
	logic                   ab_pos;
	logic                   ok;

	assign prod_aa   = a_elem * a_elem;
	assign prod_bb   = b_elem * b_elem;
	assign prod_ab   = a_elem * b_elem;
	assign cross_abs = sum_cross_q[CR_W-1] ? -sum_cross_q : sum_cross_q;
	assign mag       = cross_abs[SQ_W-1:0];

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q} + {{DW{1'b0}}, 1'b1};
	assign mid        = mid_sum[DW:1];
	assign c_full     = (DW+2)'(cda_pkg::ROUND_BASE) - $signed({1'b0, mid, 1'b0});
	assign c_abs_full = c_full[DW+1] ? -c_full : c_full;
	assign c_sq       = c_abs_full[DW-1:0] * c_abs_full[DW-1:0];

	assign ab_neg = sum_cross_q[CR_W-1];
	assign ab_pos = !ab_neg && (sum_cross_q != '0);
	assign ok     = c_neg_q ? (ab_neg && (l2_q >= macc_q)) : (!ab_pos || (l2_q <= macc_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_sq_a_q   <= '0;
			sum_sq_b_q   <= '0;
			sum_cross_q  <= '0;
			pair_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (cmd.finish) begin
			sum_sq_a_q   <= '0;
			sum_sq_b_q   <= '0;
			sum_cross_q  <= '0;
			pair_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (cmd.acc_en) begin
			if (pair_count_q < CNT_W'(MAX_LEN)) begin
				sum_sq_a_q   <= sum_sq_a_q + SQ_W'($unsigned(prod_aa));
				sum_sq_b_q   <= sum_sq_b_q + SQ_W'($unsigned(prod_bb));
				sum_cross_q  <= sum_cross_q + CR_W'(prod_ab);
				pair_count_q <= pair_count_q + CNT_W'(1);
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			macc_q <= '0;
			case (cmd.mul_sel)
				cda_pkg::MSEL_P: begin
					mx_q <= WIDE'(sum_sq_a_q);
					my_q <= sum_sq_b_q;
				end
				cda_pkg::MSEL_M: begin
					mx_q <= WIDE'(mag);
					my_q <= mag;
				end
				cda_pkg::MSEL_R: begin
					mx_q <= WIDE'(p_q);
					my_q <= SQ_W'(c2_q);
				end
				default: begin
					mx_q <= WIDE'(sum_sq_a_q);
					my_q <= sum_sq_b_q;
				end
			endcase
		end else if (cmd.mul_step) begin
			if (my_q[0]) macc_q <= macc_q + mx_q;
			mx_q <= mx_q << 1;
			my_q <= my_q >> 1;
		end
		if (cmd.save_p) p_q <= macc_q[P_W-1:0];
		if (cmd.save_l2) l2_q <= macc_q << cda_pkg::L2_SHIFT;
		if (cmd.square) begin
			mid_q   <= mid;
			c_neg_q <= c_full[DW+1];
			c2_q    <= c_sq[cda_pkg::C2_W-1:0];
		end
		if (cmd.search_init) begin
			lo_q <= '0;
			hi_q <= DW'(cda_pkg::Q14_TWO);
		end else if (cmd.decide) begin
			if (ok) lo_q <= mid_q;
			else hi_q <= mid_q - DW'(1);
		end
		if (cmd.finish) begin
			dist_q <= status.zero_norm ? '0 : lo_q;
			zn_q   <= status.zero_norm;
			tl_q   <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.zero_norm   = (sum_sq_a_q == '0) || (sum_sq_b_q == '0);
	assign status.mul_done    = (my_q == '0);
	assign status.search_done = (lo_q >= hi_q);
	assign status.out_busy    = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign distance  = dist_q;
	assign zero_norm = zn_q;
	assign too_long  = tl_q;

endmodule

// ----- rtl/cosine_distance_accumulator.sv -----
// Top level of the cosine distance accumulator
`timescale 1ns / 1ps
`include "cosine_distance_accumulator_defines.svh"
// Streams element pairs of two vectors, one pair a cycle, into three exact running
// sums (aa, bb, ab). The pair marked last closes the vector: input then stalls
// while one shift-add multiplier forms aa*bb and ab squared (with an SQ_W-bit
// multiplier operand, SQ_W = 31 + log2(MAX_LEN), 43 by default) and a 16-step binary
// search tests each candidate distance with one more shift-add multiply, then
// waits for any previous result to be taken. The distance is Q2.14, rounded to
// nearest and clamped to 0..32768; a zero norm skips the search and reports
// distance 0 with zero_norm set, and pairs beyond MAX_LEN are dropped with
// too_long set. The result sits in an output register, so the next vector
// streams in while it waits to be taken.
module cosine_distance_accumulator #(
	parameter int MAX_LEN = cda_pkg::MAX_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cda_sample_if.sink   sample,
	cda_result_if.source result
);

	cda_pkg::cda_cmd_t    cmd;
	cda_pkg::cda_status_t status;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_last  (sample.last),
		.in_ready (sample.ready),
		.status   (status),
		.cmd      (cmd)
	);

	cda_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.a_elem    (sample.a_elem),
		.b_elem    (sample.b_elem),
		.cmd       (cmd),
		.status    (status),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.distance  (result.distance),
		.zero_norm (result.zero_norm),
		.too_long  (result.too_long)
	);

	`CDA_ASSERT(a_last_stalls, sample.valid && sample.ready && sample.last |=> !sample.ready, "input not stalled after last transaction")
	`CDA_ASSERT(a_zero_norm_dist, result.valid && result.zero_norm |-> result.distance == 16'd0, "zero norm with nonzero distance")
	`CDA_ASSERT(a_dist_range, result.valid |-> result.distance <= 16'd32768, "distance above two")

endmodule
